[src/tea_block_encrypt_alt_delta_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef TEA_BLOCK_ENCRYPT_ALT_DELTA_MACROS_SVH
`define TEA_BLOCK_ENCRYPT_ALT_DELTA_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tbe_pkg.sv]
package tbe_pkg;

  localparam int unsigned WordW = 32;

  // Round constant, one below the textbook value on purpose.
  localparam logic [WordW-1:0] ROUND_DELTA = 32'h9E37_79B8;

  localparam int unsigned ShiftLeft  = 4;
  localparam int unsigned ShiftRight = 5;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t right;
    word_t left;
  } block_t;

  typedef enum logic [1:0] {
    CFG_KEY0 = 2'd0,
    CFG_KEY1 = 2'd1,
    CFG_KEY2 = 2'd2,
    CFG_KEY3 = 2'd3
  } cfg_reg_e;

endpackage

[src/tea_block_encrypt_alt_delta.sv]
// Channel   Dir  Payload
// s_axis    in   tdata[63:0] = {plain_right, plain_left}
// m_axis    out  tdata[63:0] = {cipher_right, cipher_left}
// cfg       in   index 0..3 = key word 0..3, data 32 bits
//
// The pipeline has one stage per half round, each stage one shift/add/xor
// mix and one add. One block enters per cycle while m_axis is not stalled.
// The whole pipeline holds while a result waits on m_axis_tready.
// Reset clears stage valids and the key words (all-zero key).
`include "tea_block_encrypt_alt_delta_macros.svh"

module tea_block_encrypt_alt_delta #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] plain_left, [63:32] plain_right
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] cipher_left, [63:32] cipher_right
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned NumStages = 2 * ROUND_COUNT;

  tbe_pkg::word_t  key_q [4];
  logic            pipe_en;
  logic            valid_s [NumStages+1];
  tbe_pkg::block_t blk_s   [NumStages+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= '0;
      key_q[1] <= '0;
      key_q[2] <= '0;
      key_q[3] <= '0;
    end else if (cfg_valid_i) begin
      case (tbe_pkg::cfg_reg_e'(cfg_index_i))
        tbe_pkg::CFG_KEY0: key_q[0] <= cfg_data_i;
        tbe_pkg::CFG_KEY1: key_q[1] <= cfg_data_i;
        tbe_pkg::CFG_KEY2: key_q[2] <= cfg_data_i;
        tbe_pkg::CFG_KEY3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global stall: move only when the output slot is free or being drained.
  assign pipe_en       = !valid_s[NumStages] || m_axis_tready;
  assign s_axis_tready = pipe_en;

  assign valid_s[0]      = s_axis_tvalid;
  assign blk_s[0].left   = s_axis_tdata[31:0];
  assign blk_s[0].right  = s_axis_tdata[63:32];

  for (genvar i = 0; i < NumStages; i++) begin : g_stage
    localparam logic [31:0] Sum =
      32'(64'(tbe_pkg::ROUND_DELTA) * 64'(i / 2 + 1));
    // Even stages update the left word with keys 0/1, odd ones the right with 2/3.
    localparam int unsigned KeyBase = (i % 2) * 2;

    tbe_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (valid_s[i]),
      .blk_i   (blk_s[i]),
      .ka_i    (key_q[KeyBase]),
      .kb_i    (key_q[KeyBase+1]),
      .sum_i   (Sum),
      .valid_o (valid_s[i+1]),
      .blk_o   (blk_s[i+1])
    );
  end

  assign m_axis_tvalid = valid_s[NumStages];
  assign m_axis_tdata  = {blk_s[NumStages].right, blk_s[NumStages].left};

  `TBE_ASSERT_IMP(a_stall_blocks_input, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input accepted while output stalled")
  `TBE_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or dropped")
  `TBE_ASSERT_NEXT(a_keys_stable, clk_i, rst_ni, !cfg_valid_i, $stable({key_q[0], key_q[1], key_q[2], key_q[3]}), "key changed without a write")

endmodule

[src/tbe_stage.sv]
// One half round: updates the left word from the right word, then swaps
// the halves so every stage has the same shape.
module tbe_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  tbe_pkg::block_t blk_i,
  input  tbe_pkg::word_t ka_i,
  input  tbe_pkg::word_t kb_i,
  input  tbe_pkg::word_t sum_i,
  output logic           valid_o,
  output tbe_pkg::block_t blk_o
);

  logic            valid_q;
  tbe_pkg::block_t blk_q;
  tbe_pkg::block_t blk_d;
  tbe_pkg::word_t  mix;

  always_comb begin
    mix = ((blk_i.right << tbe_pkg::ShiftLeft) + ka_i)
        ^ (blk_i.right + sum_i)
        ^ ((blk_i.right >> tbe_pkg::ShiftRight) + kb_i);
    blk_d.left  = blk_i.right;
    blk_d.right = blk_i.left + mix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule
